// ===== hw/rtl/tdrm_pkg.sv =====
`default_nettype none
package tdrm_pkg;

  // field widths
  localparam int OP_W      = 2;
  localparam int POS_W     = 11;
  localparam int RANGE_W   = 8;
  localparam int PLAYER_W  = 4;
  localparam int PL_W      = PLAYER_W - 1;
  localparam int REG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // tile geometry in world units
  localparam int TILE_UNITS = 16;
  localparam int TILE_SHIFT = $clog2(TILE_UNITS);
  localparam int HALF_TILE  = TILE_UNITS / 2;

  // centre, centre + reach, tile index, edge distance, squares, reach limit
  localparam int CX_W   = POS_W + TILE_SHIFT;
  localparam int EXT_W  = CX_W + 1;
  localparam int TW     = EXT_W - TILE_SHIFT;
  localparam int DIST_W = RANGE_W;
  localparam int SQ_W   = 2 * DIST_W;
  localparam int LIM_W  = 2 * (RANGE_W + 1);

  localparam logic [OP_W-1:0] OP_STAMP_WORLD = 2'd0;
  localparam logic [OP_W-1:0] OP_STAMP_TILE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] MAP_REG_RESET = 8'd128;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_QREAD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic setup;
    logic scan;
    logic qread;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic is_stamp;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tdrm_mem.sv =====
`default_nettype none
module tdrm_mem #(
  parameter int AW = 14,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wmask,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // bit-masked write, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < DW; b++) begin
        if (wmask[b]) begin
          mem[waddr][b] <= wdata[b];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tdrm_ctrl.sv =====
`default_nettype none
module tdrm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tdrm_pkg::dp_sts_t  sts,
  output tdrm_pkg::dp_cmd_t  cmd
);

  tdrm_pkg::state_t state;
  tdrm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdrm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tdrm_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_next = tdrm_pkg::ST_IDLE;
      end
      tdrm_pkg::ST_IDLE: begin
        if (in_valid) state_next = tdrm_pkg::ST_SETUP;
      end
      tdrm_pkg::ST_SETUP: begin
        if (sts.is_query)      state_next = tdrm_pkg::ST_QREAD;
        else if (sts.is_stamp) state_next = tdrm_pkg::ST_SCAN;
        else                   state_next = tdrm_pkg::ST_RESP;
      end
      tdrm_pkg::ST_SCAN: begin
        if (sts.scan_last) state_next = tdrm_pkg::ST_DRAIN;
      end
      tdrm_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) state_next = tdrm_pkg::ST_RESP;
      end
      tdrm_pkg::ST_QREAD: begin
        state_next = tdrm_pkg::ST_RESP;
      end
      tdrm_pkg::ST_RESP: begin
        if (sts.out_free) state_next = tdrm_pkg::ST_IDLE;
      end
      default: begin
        state_next = tdrm_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      tdrm_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      tdrm_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      tdrm_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      tdrm_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      tdrm_pkg::ST_QREAD: begin
        cmd.qread = 1'b1;
      end
      tdrm_pkg::ST_RESP: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tdrm_dp.sv =====
`default_nettype none
module tdrm_dp #(
  parameter int MAP_SIDE = 128,
  parameter int PLAYERS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tdrm_pkg::dp_cmd_t                     cmd,
  output tdrm_pkg::dp_sts_t                     sts,
  input  logic [tdrm_pkg::OP_W-1:0]             op,
  input  logic [tdrm_pkg::POS_W-1:0]            pos_x,
  input  logic [tdrm_pkg::POS_W-1:0]            pos_y,
  input  logic                                  odd_x,
  input  logic                                  odd_y,
  input  logic [tdrm_pkg::RANGE_W-1:0]          vis_range,
  input  logic signed [tdrm_pkg::PLAYER_W-1:0]  player,
  input  logic                                  cfg_we,
  input  logic [tdrm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tdrm_pkg::REG_W-1:0]            cfg_data,
  output logic                                  mem_we,
  output logic [2*$clog2(MAP_SIDE)-1:0]         mem_waddr,
  output logic [PLAYERS-1:0]                    mem_wmask,
  output logic [PLAYERS-1:0]                    mem_wdata,
  output logic                                  mem_re,
  output logic [2*$clog2(MAP_SIDE)-1:0]         mem_raddr,
  input  logic [PLAYERS-1:0]                    mem_rdata,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  explored_bit,
  output logic                                  was_query
);

  localparam int IDX_W  = $clog2(MAP_SIDE);
  localparam int AW     = 2 * IDX_W;
  localparam int TW     = tdrm_pkg::TW;
  localparam int CX_W   = tdrm_pkg::CX_W;
  localparam int EXT_W  = tdrm_pkg::EXT_W;
  localparam int DIST_W = tdrm_pkg::DIST_W;
  localparam int SQ_W   = tdrm_pkg::SQ_W;
  localparam int LIM_W  = tdrm_pkg::LIM_W;
  localparam int PL_W   = tdrm_pkg::PL_W;
  localparam int TS     = tdrm_pkg::TILE_SHIFT;

  // distance from centre c to the nearer world edge of tile t
  function automatic logic [DIST_W-1:0] near_dist(input logic [TW-1:0] t,
                                                   input logic [CX_W-1:0] c);
    logic signed [EXT_W+1:0] d_lo;
    logic signed [EXT_W+1:0] d_hi;
    logic [EXT_W+1:0]        a_lo;
    logic [EXT_W+1:0]        a_hi;
    d_lo = $signed({2'b00, t, {TS{1'b0}}}) - $signed({{(EXT_W+2-CX_W){1'b0}}, c});
    d_hi = d_lo + $signed((EXT_W+2)'(tdrm_pkg::TILE_UNITS - 1));
    a_lo = d_lo[EXT_W+1] ? unsigned'(-d_lo) : unsigned'(d_lo);
    a_hi = d_hi[EXT_W+1] ? unsigned'(-d_hi) : unsigned'(d_hi);
    return (a_lo < a_hi) ? a_lo[DIST_W-1:0] : a_hi[DIST_W-1:0];
  endfunction

  // config
  logic [tdrm_pkg::REG_W-1:0] map_w;
  logic [tdrm_pkg::REG_W-1:0] map_h;

  // latched item
  logic [tdrm_pkg::OP_W-1:0]    lat_op;
  logic [tdrm_pkg::POS_W-1:0]   lat_px;
  logic [tdrm_pkg::POS_W-1:0]   lat_py;
  logic [CX_W-1:0]              lat_cx;
  logic [CX_W-1:0]              lat_cy;
  logic [tdrm_pkg::RANGE_W-1:0] lat_reach;
  logic [PL_W-1:0]              lat_pl;
  logic                         lat_pl_ok;

  // box and scan
  logic [TW-1:0]    tx;
  logic [TW-1:0]    ty;
  logic [TW-1:0]    x1;
  logic [TW-1:0]    y0;
  logic [TW-1:0]    y1;
  logic             box_empty;
  logic [LIM_W-1:0] limit;
  logic             q_ok;

  // distance stage
  logic            s1_valid;
  logic [SQ_W-1:0] s1_dx2;
  logic [SQ_W-1:0] s1_dy2;
  logic [AW-1:0]   s1_addr;

  logic [AW-1:0] clr_cnt;

  // combinational
  logic [CX_W-1:0]              cx_in;
  logic [CX_W-1:0]              cy_in;
  logic                         pl_ok_in;
  logic [TW-1:0]                uw;
  logic [TW-1:0]                uh;
  logic [EXT_W-1:0]             x_lo;
  logic [EXT_W-1:0]             y_lo;
  logic [EXT_W-1:0]             x_hi;
  logic [EXT_W-1:0]             y_hi;
  logic [TW-1:0]                x0_c;
  logic [TW-1:0]                y0_c;
  logic [TW-1:0]                x1_c;
  logic [TW-1:0]                y1_c;
  logic [tdrm_pkg::RANGE_W:0]   r1;
  logic [DIST_W-1:0]            dx;
  logic [DIST_W-1:0]            dy;
  logic                         hit;
  logic [PLAYERS-1:0]           pl_mask;
  logic                         q_bit;
  logic                         is_query;

  assign is_query = (lat_op == tdrm_pkg::OP_QUERY);

  always_comb begin
    if (op == tdrm_pkg::OP_STAMP_TILE) begin
      cx_in = (CX_W'(pos_x) << TS) |
              (odd_x ? CX_W'(tdrm_pkg::HALF_TILE) : {CX_W{1'b0}});
      cy_in = (CX_W'(pos_y) << TS) |
              (odd_y ? CX_W'(tdrm_pkg::HALF_TILE) : {CX_W{1'b0}});
    end else begin
      cx_in = CX_W'(pos_x);
      cy_in = CX_W'(pos_y);
    end
    pl_ok_in = !player[tdrm_pkg::PLAYER_W-1] && (32'(player[PL_W-1:0]) < PLAYERS);
  end

  // clip box to map in use
  always_comb begin
    uw   = (TW'(map_w) > TW'(MAP_SIDE)) ? TW'(MAP_SIDE) : TW'(map_w);
    uh   = (TW'(map_h) > TW'(MAP_SIDE)) ? TW'(MAP_SIDE) : TW'(map_h);
    x_lo = EXT_W'(lat_cx) - EXT_W'(lat_reach);
    y_lo = EXT_W'(lat_cy) - EXT_W'(lat_reach);
    x_hi = EXT_W'(lat_cx) + EXT_W'(lat_reach);
    y_hi = EXT_W'(lat_cy) + EXT_W'(lat_reach);
    x0_c = x_lo[EXT_W-1] ? {TW{1'b0}} : x_lo[EXT_W-1:TS];
    y0_c = y_lo[EXT_W-1] ? {TW{1'b0}} : y_lo[EXT_W-1:TS];
    x1_c = (x_hi[EXT_W-1:TS] >= uw) ? uw - TW'(1) : x_hi[EXT_W-1:TS];
    y1_c = (y_hi[EXT_W-1:TS] >= uh) ? uh - TW'(1) : y_hi[EXT_W-1:TS];
    r1   = {1'b0, lat_reach} + 1'b1;
  end

  always_comb begin
    dx  = near_dist(tx, lat_cx);
    dy  = near_dist(ty, lat_cy);
    hit = s1_valid && ((LIM_W'(s1_dx2) + LIM_W'(s1_dy2)) < limit);
    q_bit = 1'b0;
    for (int b = 0; b < PLAYERS; b++) begin
      pl_mask[b] = (32'(lat_pl) == b);
      if (32'(lat_pl) == b) q_bit = mem_rdata[b];
    end
  end

  // memory ports
  always_comb begin
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wmask = {PLAYERS{1'b1}};
      mem_wdata = {PLAYERS{1'b0}};
    end else begin
      mem_we    = hit;
      mem_waddr = s1_addr;
      mem_wmask = pl_mask;
      mem_wdata = {PLAYERS{1'b1}};
    end
    mem_re    = cmd.qread;
    mem_raddr = {lat_py[IDX_W-1:0], lat_px[IDX_W-1:0]};
  end

  always_comb begin
    sts.clr_last  = (clr_cnt == {AW{1'b1}});
    sts.is_query  = is_query;
    sts.is_stamp  = lat_pl_ok && (lat_op == tdrm_pkg::OP_STAMP_WORLD ||
                                  lat_op == tdrm_pkg::OP_STAMP_TILE);
    sts.scan_last = box_empty || (tx == x1 && ty == y1);
    sts.pipe_busy = s1_valid;
    sts.out_free  = !out_valid || !out_stall;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_w     <= tdrm_pkg::MAP_REG_RESET;
      map_h     <= tdrm_pkg::MAP_REG_RESET;
      clr_cnt   <= {AW{1'b0}};
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tdrm_pkg::CFG_MAP_WIDTH:  map_w <= cfg_data;
          tdrm_pkg::CFG_MAP_HEIGHT: map_h <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      s1_valid <= cmd.scan && !box_empty;
      if (cmd.load_out)    out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_op    <= op;
      lat_px    <= pos_x;
      lat_py    <= pos_y;
      lat_cx    <= cx_in;
      lat_cy    <= cy_in;
      lat_reach <= vis_range;
      lat_pl    <= player[PL_W-1:0];
      lat_pl_ok <= pl_ok_in;
    end
    if (cmd.setup) begin
      tx        <= x0_c;
      ty        <= y0_c;
      x1        <= x1_c;
      y0        <= y0_c;
      y1        <= y1_c;
      box_empty <= (uw == {TW{1'b0}}) || (uh == {TW{1'b0}}) ||
                   (x0_c > x1_c) || (y0_c > y1_c);
      limit     <= LIM_W'(r1) * LIM_W'(r1);
      q_ok      <= is_query && lat_pl_ok &&
                   (TW'(lat_px) < uw) && (TW'(lat_py) < uh);
    end
    if (cmd.scan && !box_empty) begin
      s1_dx2  <= SQ_W'(dx) * SQ_W'(dx);
      s1_dy2  <= SQ_W'(dy) * SQ_W'(dy);
      s1_addr <= {ty[IDX_W-1:0], tx[IDX_W-1:0]};
      if (ty == y1) begin
        ty <= y0;
        tx <= tx + 1'b1;
      end else begin
        ty <= ty + 1'b1;
      end
    end
    if (cmd.load_out) begin
      explored_bit <= q_ok && q_bit;
      was_query    <= is_query;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tile_disc_reveal_map_core.sv =====
`default_nettype none
// Channel | Dir | Handshake           | Word
// input   | in  | in_valid / in_stall | op, pos_x, pos_y, odd_x, odd_y, vis_range, player
// result  | out | out_valid/out_stall | explored_bit, was_query
// config  | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (0 map_width, 1 map_height)
//
// After reset the explored memory is swept clear, one entry per cycle, over all
// 2**(2*clog2(MAP_SIDE)) entries (16384 at defaults); input stalls meanwhile.
// A stamp scans the N tiles of its clipped box (up to 33 x 33 = 1089), one
// tile per cycle, then drains the distance stage before its result is loaded.
// A query uses a registered memory read; a no-op word goes straight to its result.
// A finished result waits in the output register; the next word can be taken
// in the cycle after that result is loaded, even while out_stall holds it.
module tile_disc_reveal_map_core #(
  parameter int MAP_SIDE = 128,
  parameter int PLAYERS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [tdrm_pkg::OP_W-1:0]             op,
  input  logic [tdrm_pkg::POS_W-1:0]            pos_x,
  input  logic [tdrm_pkg::POS_W-1:0]            pos_y,
  input  logic                                  odd_x,
  input  logic                                  odd_y,
  input  logic [tdrm_pkg::RANGE_W-1:0]          vis_range,
  input  logic signed [tdrm_pkg::PLAYER_W-1:0]  player,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  explored_bit,
  output logic                                  was_query,
  // config channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tdrm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tdrm_pkg::REG_W-1:0]            cfg_data
);

  localparam int AW = 2 * $clog2(MAP_SIDE);

  tdrm_pkg::dp_cmd_t cmd;
  tdrm_pkg::dp_sts_t sts;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [PLAYERS-1:0] mem_wmask;
  logic [PLAYERS-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [PLAYERS-1:0] mem_rdata;

  // the user must keep registers to change only while idle; the block does not enforce it, writes are always taken
  assign cfg_ready = 1'b1;

  tdrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdrm_dp #(
    .MAP_SIDE (MAP_SIDE),
    .PLAYERS  (PLAYERS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .odd_x        (odd_x),
    .odd_y        (odd_y),
    .vis_range    (vis_range),
    .player       (player),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wmask    (mem_wmask),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .explored_bit (explored_bit),
    .was_query    (was_query)
  );

  // one bit per player per tile, rows padded to a power of two
  tdrm_mem #(
    .AW (AW),
    .DW (PLAYERS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wmask (mem_wmask),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef SYNTH
  // an accepted word keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // clearing sweep never overlaps scan writes or query reads
  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.scan && !cmd.qread)
    else $error("clear overlaps scan or query");

  // a query read only after all stamp writes have landed
  a_read_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.qread |-> !sts.pipe_busy)
    else $error("query read with stamp writes pending");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load lost");
`endif

endmodule
`default_nettype wire

// ===== bench/reveal_map_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Watches the input, result and config channels and predicts every result word.
// Results must match the oldest outstanding prediction field by field.
module reveal_map_checker #(
  parameter int MAP_SIDE = 128,
  parameter int PLAYERS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [tdrm_pkg::OP_W-1:0]             op,
  input  logic [tdrm_pkg::POS_W-1:0]            pos_x,
  input  logic [tdrm_pkg::POS_W-1:0]            pos_y,
  input  logic                                  odd_x,
  input  logic                                  odd_y,
  input  logic [tdrm_pkg::RANGE_W-1:0]          vis_range,
  input  logic signed [tdrm_pkg::PLAYER_W-1:0]  player,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic                                  explored_bit,
  input  logic                                  was_query,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [tdrm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tdrm_pkg::REG_W-1:0]            cfg_data,
  output int                                    errors,
  output int                                    pending
);

  typedef struct packed {
    logic explored_bit;
    logic was_query;
  } answer_t;

  answer_t                    answers_due[$];
  logic [PLAYERS-1:0]         revealed [MAP_SIDE*MAP_SIDE];
  logic [tdrm_pkg::REG_W-1:0] cols_reg;
  logic [tdrm_pkg::REG_W-1:0] rows_reg;
  int                         mism = 0;
  int                         words_seen = 0;

  assign errors = mism;

  task automatic flag_mismatch(input string what);
    $display("%0t reveal_map_checker: result word %0d: %s", $realtime, words_seen, what);
    mism++;
  endtask

  // columns / rows in use; registers above the store size saturate
  function automatic int in_use(input logic [tdrm_pkg::REG_W-1:0] r);
    return (int'(r) > MAP_SIDE) ? MAP_SIDE : int'(r);
  endfunction

  // distance from centre to the nearer world edge of a tile
  function automatic int near_gap(input int tile, input int c);
    int a;
    int b;
    a = tile * tdrm_pkg::TILE_UNITS - c;
    b = (tile + 1) * tdrm_pkg::TILE_UNITS - 1 - c;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    return (a < b) ? a : b;
  endfunction

  task automatic reveal_disc(input int cx, input int cy, input int reach, input int pl);
    int x0;
    int y0;
    int x1;
    int y1;
    int lim;
    int dx;
    int dy;
    x0 = (cx - reach < 0) ? 0 : (cx - reach) / tdrm_pkg::TILE_UNITS;
    y0 = (cy - reach < 0) ? 0 : (cy - reach) / tdrm_pkg::TILE_UNITS;
    x1 = (cx + reach) / tdrm_pkg::TILE_UNITS;
    y1 = (cy + reach) / tdrm_pkg::TILE_UNITS;
    if (x1 > in_use(cols_reg) - 1) x1 = in_use(cols_reg) - 1;
    if (y1 > in_use(rows_reg) - 1) y1 = in_use(rows_reg) - 1;
    lim = (reach + 1) * (reach + 1);
    for (int tx = x0; tx <= x1; tx++) begin
      dx = near_gap(tx, cx);
      for (int ty = y0; ty <= y1; ty++) begin
        dy = near_gap(ty, cy);
        if (dx * dx + dy * dy < lim) revealed[ty * MAP_SIDE + tx][pl] = 1'b1;
      end
    end
  endtask

  task automatic predict_word(output answer_t a);
    int  pl;
    int  px;
    int  py;
    logic owner_ok;
    pl = int'($unsigned(player));
    px = int'(pos_x);
    py = int'(pos_y);
    owner_ok = (pl < (1 << tdrm_pkg::PL_W)) && (pl < PLAYERS);
    a = '0;
    case (op)
      tdrm_pkg::OP_QUERY: begin
        a.was_query = 1'b1;
        if (owner_ok && px < in_use(cols_reg) && py < in_use(rows_reg))
          a.explored_bit = revealed[py * MAP_SIDE + px][pl];
      end
      tdrm_pkg::OP_STAMP_WORLD: begin
        if (owner_ok) reveal_disc(px, py, int'(vis_range), pl);
      end
      tdrm_pkg::OP_STAMP_TILE: begin
        if (owner_ok)
          reveal_disc(px * tdrm_pkg::TILE_UNITS + (odd_x ? tdrm_pkg::HALF_TILE : 0),
                      py * tdrm_pkg::TILE_UNITS + (odd_y ? tdrm_pkg::HALF_TILE : 0),
                      int'(vis_range), pl);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    answer_t want;
    if (rst) begin
      foreach (revealed[i]) revealed[i] = '0;
      cols_reg = tdrm_pkg::MAP_REG_RESET;
      rows_reg = tdrm_pkg::MAP_REG_RESET;
      answers_due.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          flag_mismatch("result word with nothing outstanding");
        end else begin
          want = answers_due.pop_front();
          if (explored_bit !== want.explored_bit)
            flag_mismatch($sformatf("explored_bit %b, expected %b",
                                    explored_bit, want.explored_bit));
          if (was_query !== want.was_query)
            flag_mismatch($sformatf("was_query %b, expected %b", was_query, want.was_query));
        end
        words_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tdrm_pkg::CFG_MAP_WIDTH:  cols_reg = cfg_data;
          tdrm_pkg::CFG_MAP_HEIGHT: rows_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_word(want);
        answers_due.insert(answers_due.size(), want);
      end
      pending <= answers_due.size();
    end
  end

endmodule
`default_nettype wire

// ===== bench/tile_disc_reveal_map_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tile_disc_reveal_map_core_tb;

  localparam int MAP_SIDE  = 128;
  localparam int N_PLAYERS = 8;
  // op code the block has no use for; must still give one empty result
  localparam logic [tdrm_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic [tdrm_pkg::OP_W-1:0]             op = tdrm_pkg::OP_QUERY;
  logic [tdrm_pkg::POS_W-1:0]            pos_x = '0;
  logic [tdrm_pkg::POS_W-1:0]            pos_y = '0;
  logic                                  odd_x = 1'b0;
  logic                                  odd_y = 1'b0;
  logic [tdrm_pkg::RANGE_W-1:0]          vis_range = '0;
  logic signed [tdrm_pkg::PLAYER_W-1:0]  player = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic                                  explored_bit;
  logic                                  was_query;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [tdrm_pkg::CFG_IDX_W-1:0]        cfg_index = tdrm_pkg::CFG_MAP_WIDTH;
  logic [tdrm_pkg::REG_W-1:0]            cfg_data = '0;

  int errors;
  int pending;

  // traffic knobs: idle_pct is only touched by the stimulus process,
  // stall_pct / hold_req cross into the result side and go through NBAs
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_len  = 0;
  int   sent      = 0;
  // our copy of the map size, only used to aim stamps and queries
  logic [tdrm_pkg::REG_W-1:0] cols_set = tdrm_pkg::MAP_REG_RESET;
  logic [tdrm_pkg::REG_W-1:0] rows_set = tdrm_pkg::MAP_REG_RESET;

  always #2 clk = ~clk;

  tile_disc_reveal_map_core #(
    .MAP_SIDE(MAP_SIDE),
    .PLAYERS (N_PLAYERS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .odd_x       (odd_x),
    .odd_y       (odd_y),
    .vis_range   (vis_range),
    .player      (player),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .explored_bit(explored_bit),
    .was_query   (was_query),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  reveal_map_checker #(
    .MAP_SIDE(MAP_SIDE),
    .PLAYERS (N_PLAYERS)
  ) chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .odd_x       (odd_x),
    .odd_y       (odd_y),
    .vis_range   (vis_range),
    .player      (player),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .explored_bit(explored_bit),
    .was_query   (was_query),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending)
  );

  // Result side. A hold request parks out_stall high for a span set by hold_len,
  // counted here, once; the sender keeps pushing words meanwhile so the
  // core's output register and work stage fill and in_stall comes up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one word, with random idle cycles ahead of it; returns once taken.
  // in_valid stays high on exit so back-to-back words need no extra NBA.
  task automatic send_word(input logic [tdrm_pkg::OP_W-1:0] o, input int px, input int py,
                           input logic ox, input logic oy, input int rng, input int pl);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    pos_x     <= px[tdrm_pkg::POS_W-1:0];
    pos_y     <= py[tdrm_pkg::POS_W-1:0];
    odd_x     <= ox;
    odd_y     <= oy;
    vis_range <= rng[tdrm_pkg::RANGE_W-1:0];
    player    <= pl[tdrm_pkg::PLAYER_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drain: nothing outstanding, then spare cycles.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register writes only land on an idle core.
  task automatic set_reg(input logic [tdrm_pkg::CFG_IDX_W-1:0] idx,
                         input logic [tdrm_pkg::REG_W-1:0] val);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == tdrm_pkg::CFG_MAP_WIDTH) cols_set = val;
    else rows_set = val;
  endtask

  // Well-formed traffic: one stamp somewhere on the map, then a few queries
  // scattered around its disc, mostly by the same player.
  task automatic reveal_episode();
    int   w;
    int   h;
    int   tx;
    int   ty;
    int   rng;
    int   pl;
    int   spread;
    int   qx;
    int   qy;
    logic ox;
    logic oy;
    w  = (cols_set > MAP_SIDE) ? MAP_SIDE : int'(cols_set);
    h  = (rows_set > MAP_SIDE) ? MAP_SIDE : int'(rows_set);
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    tx  = $urandom_range(0, w - 1);
    ty  = $urandom_range(0, h - 1);
    // small reach keeps stamps short; one in five goes full range
    rng = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 48);
    pl  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, N_PLAYERS - 1);
    ox  = 1'($urandom_range(0, 1));
    oy  = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1))
      send_word(tdrm_pkg::OP_STAMP_WORLD,
                tx * tdrm_pkg::TILE_UNITS + $urandom_range(0, tdrm_pkg::TILE_UNITS - 1),
                ty * tdrm_pkg::TILE_UNITS + $urandom_range(0, tdrm_pkg::TILE_UNITS - 1),
                ox, oy, rng, pl);
    else
      send_word(tdrm_pkg::OP_STAMP_TILE, tx, ty, ox, oy, rng, pl);
    spread = rng / tdrm_pkg::TILE_UNITS + 2;
    repeat ($urandom_range(1, 4)) begin
      qx = tx + int'($urandom_range(0, 2 * spread)) - spread;
      qy = ty + int'($urandom_range(0, 2 * spread)) - spread;
      if (qx < 0) qx = 0;
      if (qy < 0) qy = 0;
      send_word(tdrm_pkg::OP_QUERY, qx, qy, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom_range(0, 255),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : pl);
    end
  endtask

  // Noise: any op, any field value over the full port widths.
  task automatic noise_word();
    send_word(2'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom_range(0, 2047),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(0, 255),
              $urandom_range(0, 15));
  endtask

  // hold: if nonzero, the result side holds off once, for a span set by hold,
  // after the registers are set, while the words of this phase keep coming
  task automatic run_phase(input int n, input logic [tdrm_pkg::REG_W-1:0] w,
                           input logic [tdrm_pkg::REG_W-1:0] h,
                           input int idle, input int stall, input int hold);
    int target;
    set_reg(tdrm_pkg::CFG_MAP_WIDTH, w);
    set_reg(tdrm_pkg::CFG_MAP_HEIGHT, h);
    idle_pct = idle;
    stall_pct <= stall;
    if (hold != 0) begin
      hold_len = hold;
      hold_req <= 1'b1;
    end
    target = sent + n;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 7) reveal_episode();
      else noise_word();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed words, reset map size 128 x 128 ---
    send_word(tdrm_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);                // clean map reads 0
    send_word(tdrm_pkg::OP_STAMP_WORLD, 0, 0, 0, 0, 0, 0);          // zero reach, corner
    send_word(tdrm_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
    send_word(tdrm_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1);                // other player untouched
    send_word(tdrm_pkg::OP_STAMP_TILE, 127, 127, 1, 1, 255, 7);     // max reach, far corner
    send_word(tdrm_pkg::OP_QUERY, 127, 127, 0, 0, 0, 7);
    send_word(tdrm_pkg::OP_QUERY, 112, 112, 0, 0, 0, 7);
    send_word(tdrm_pkg::OP_STAMP_WORLD, 2047, 2047, 1, 1, 255, -1); // negative player: no-op
    send_word(tdrm_pkg::OP_QUERY, 127, 127, 0, 0, 0, -1);           // negative player reads 0
    send_word(tdrm_pkg::OP_STAMP_TILE, 20, 20, 0, 0, 255, 8);       // player past the last one
    send_word(tdrm_pkg::OP_QUERY, 20, 20, 0, 0, 0, 0);
    send_word(tdrm_pkg::OP_STAMP_TILE, 2047, 2047, 1, 1, 255, 3);   // centre past the map
    send_word(tdrm_pkg::OP_QUERY, 2047, 2047, 1, 1, 255, 3);        // query outside the map
    send_word(OP_SPARE, 2047, 2047, 1, 1, 255, 7);                  // unused op, all ones but player sign bit
    send_word(tdrm_pkg::OP_STAMP_WORLD, 1000, 500, 0, 0, 40, 2);
    send_word(tdrm_pkg::OP_QUERY, 62, 31, 0, 0, 0, 2);
    send_word(tdrm_pkg::OP_QUERY, 65, 31, 0, 0, 0, 2);
    send_word(tdrm_pkg::OP_QUERY, 62, 35, 0, 0, 0, 2);
    send_word(tdrm_pkg::OP_STAMP_TILE, 10, 10, 0, 1, 8, 5);         // half tile on one axis
    send_word(tdrm_pkg::OP_QUERY, 10, 11, 0, 0, 0, 5);
    send_word(tdrm_pkg::OP_QUERY, 11, 11, 0, 0, 0, 5);

    // one-tile map
    set_reg(tdrm_pkg::CFG_MAP_WIDTH, 8'd1);
    set_reg(tdrm_pkg::CFG_MAP_HEIGHT, 8'd1);
    send_word(tdrm_pkg::OP_STAMP_WORLD, 5, 5, 0, 0, 255, 4);
    send_word(tdrm_pkg::OP_QUERY, 0, 0, 0, 0, 0, 4);
    send_word(tdrm_pkg::OP_QUERY, 1, 0, 0, 0, 0, 4);

    // empty map: stamps mark nothing, queries read 0
    set_reg(tdrm_pkg::CFG_MAP_WIDTH, 8'd0);
    set_reg(tdrm_pkg::CFG_MAP_HEIGHT, 8'd0);
    send_word(tdrm_pkg::OP_STAMP_TILE, 0, 0, 0, 0, 100, 6);
    send_word(tdrm_pkg::OP_QUERY, 0, 0, 0, 0, 0, 6);

    // oversized registers saturate to the store size
    set_reg(tdrm_pkg::CFG_MAP_WIDTH, 8'd255);
    set_reg(tdrm_pkg::CFG_MAP_HEIGHT, 8'd200);
    send_word(tdrm_pkg::OP_STAMP_TILE, 127, 127, 0, 0, 60, 1);
    send_word(tdrm_pkg::OP_QUERY, 127, 127, 0, 0, 0, 1);

    // --- random phases ---
    run_phase(90, 8'd128, 8'd128, 0, 0, 0);   // no idling at all

    // long hold on the result side while words keep coming
    run_phase(40, 8'd128, 8'd128, 0, 0, 2000);

    run_phase(90, 8'd37, 8'd90, 60, 0, 0);    // sender idle
    run_phase(90, 8'd255, 8'd255, 0, 60, 0);  // receiver stalling
    run_phase(60, 8'd1, 8'd128, 6, 6, 0);
    run_phase(60, 8'd128, 8'd1, 6, 6, 0);
    run_phase(90, 8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)), 6, 6, 0);

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tile_disc_reveal_map_core_tb: clean");
    else
      $display("tile_disc_reveal_map_core_tb: errors");
    $finish;
  end

  // Hard stop: 12 ms, several times the slowest legal run including the
  // post-reset clear sweep and full-reach stamps under heavy stall.
  initial begin
    #12_000_000;
    $display("tile_disc_reveal_map_core_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
